[sv/rvie_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvie_pkg
// shared types, opcodes and csr numbers of the rv32im instruction executor
// ----------------------------------------------------------------------------
package rvie_pkg;

   localparam int REG_COUNT = 32;
   localparam int REG_AW = $clog2(REG_COUNT);
   localparam int CSR_COUNT = 10;
   localparam int MD_STEPS = 32;

   localparam logic [31:0] RESET_VECTOR = 32'h8000_0000;

   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [6:0] F7_BASE   = 7'h00;
   localparam logic [6:0] F7_MULDIV = 7'h01;
   localparam logic [6:0] F7_ALT    = 7'h20;

   localparam logic [31:0] INSN_MRET   = 32'h3020_0073;
   localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
   localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;

   localparam logic [4:0] REG_A0 = 5'd10;
   localparam logic [4:0] REG_A7 = 5'd17;

   localparam logic [3:0] CSR_MSTATUS_IX = 4'd0;
   localparam logic [3:0] CSR_MTVEC_IX   = 4'd3;
   localparam logic [3:0] CSR_MEPC_IX    = 4'd4;
   localparam logic [3:0] CSR_MCAUSE_IX  = 4'd5;

   localparam logic [11:0] CSR_NUM [CSR_COUNT] = '{
      12'h300, 12'h301, 12'h304, 12'h305, 12'h341,
      12'h342, 12'h343, 12'h344, 12'h180, 12'h340
   };

   typedef enum logic [2:0] {
      K_RETIRED = 3'd0,
      K_LOAD    = 3'd1,
      K_STORE   = 3'd2,
      K_HALT    = 3'd3,
      K_INVALID = 3'd4,
      K_BADCSR  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_MD,
      S_FIN
   } state_type;

   // csr number to file index, hit flag in the top bit
   function automatic logic [4:0] csr_lookup(input logic [11:0] num);
      logic [4:0] res;
      res = '0;
      for (int k = 0; k < CSR_COUNT; k++) begin
         if (CSR_NUM[k] == num) res = {1'b1, 4'(k)};
      end
      return res;
   endfunction

endpackage

[sv/rv32im_instruction_executor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32im_instruction_executor
// machine-mode rv32im core executing one externally fetched instruction per
// request, with a bit-serial multiply / divide unit
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  req_      in         req_valid/stall     op, instruction, load_data
//  rsp_      out        rsp_valid/stall     kind, mem_*, next_pc, exit_code
//  csr_      in         csr_write_enable    write_data (loads the pc)
//
//  ordinary requests run a register file read, then execute/commit
//  multiply and divide use a shift-add / restoring-divide unit that retires
//  one bit of the operand per cycle over 32 steps
//  synchronous active-high reset clears control state, pc to 0x80000000
//  a request is taken only in idle; commit waits while the result register is
//  full and stalled
// ----------------------------------------------------------------------------
module rv32im_instruction_executor
   import rvie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_instruction,
   input  logic [31:0] req_load_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_mem_address,
   output logic [31:0] rsp_mem_write_data,
   output logic [2:0]  rsp_mem_size,
   output logic [31:0] rsp_next_pc,
   output logic [31:0] rsp_exit_code
);

   // control state
   state_type state_ff, state_in;
   logic [31:0] pc_ff;
   logic        halted_ff;
   logic        ld_pend_ff;
   logic [4:0]  ld_dest_ff;
   logic [1:0]  ld_width_ff;
   logic        ld_signed_ff;
   logic [31:0] csr_file_ff [CSR_COUNT];

   // latched request
   logic        op_ff;
   logic [31:0] ins_ff;
   logic [31:0] ldata_ff;

   // register file, valid bits stand in for the zero reset
   logic [31:0]          reg_mem [REG_COUNT];
   logic [REG_COUNT-1:0] reg_vld_ff;
   logic [31:0]          a_raw_ff, b_raw_ff;
   logic                 a_ok_ff, b_ok_ff;

   // bit-serial multiply / divide
   logic [32:0] md_hi_ff;
   logic [31:0] md_lo_ff;
   logic [31:0] md_opnd_ff;
   logic [4:0]  md_cnt_ff;

   // result register
   logic        rsp_valid_ff;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic [31:0] rsp_wdata_ff, rsp_wdata_in;
   logic [2:0]  rsp_size_ff, rsp_size_in;
   logic [31:0] rsp_npc_ff, rsp_npc_in;
   logic [31:0] rsp_code_ff, rsp_code_in;

   logic accept, out_free, commit, is_md, is_div;
   logic [4:0] ra, rb;
   logic [31:0] a, b;

   // decode of the latched word
   logic [6:0]  opc, f7;
   logic [2:0]  f3;
   logic [4:0]  rd;
   logic [31:0] immi, imms, immb, immu, immj, pc4;

   // commit side effects
   logic        wb_en;
   logic [4:0]  wb_addr;
   logic [31:0] wb_data;
   logic        reg_we;
   logic        pc_we;
   logic [31:0] pc_in;
   logic        csr_we, do_ecall, ld_set, ld_clr, halt_set;
   logic [3:0]  csr_ix;
   logic [31:0] csr_wdata;
   logic [31:0] md_result;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign opc  = ins_ff[6:0];
   assign f3   = ins_ff[14:12];
   assign f7   = ins_ff[31:25];
   assign rd   = ins_ff[11:7];
   assign immi = {{20{ins_ff[31]}}, ins_ff[31:20]};
   assign imms = {{20{ins_ff[31]}}, ins_ff[31:25], ins_ff[11:7]};
   assign immb = {{19{ins_ff[31]}}, ins_ff[31], ins_ff[7], ins_ff[30:25],
                  ins_ff[11:8], 1'b0};
   assign immu = {ins_ff[31:12], 12'd0};
   assign immj = {{11{ins_ff[31]}}, ins_ff[31], ins_ff[19:12], ins_ff[20],
                  ins_ff[30:21], 1'b0};
   assign pc4  = pc_ff + 32'd4;

   assign a = a_ok_ff ? a_raw_ff : 32'd0;
   assign b = b_ok_ff ? b_raw_ff : 32'd0;

   assign is_md  = !op_ff && !halted_ff && !ld_pend_ff && (opc == OPC_OP)
                   && (f7 == F7_MULDIV);
   assign is_div = f3[2];
   assign commit = out_free && (((state_ff == S_EXEC) && !is_md) || (state_ff == S_FIN));

   // read addresses: a0 for the halt code, a7 for ecall
   always_comb begin
      ra = req_instruction[19:15];
      rb = req_instruction[24:20];
      if (halted_ff || (req_instruction == INSN_EBREAK)) ra = REG_A0;
      else if (req_instruction == INSN_ECALL) ra = REG_A7;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_EXEC;
         S_EXEC: begin
            if (is_md) state_in = S_MD;
            else if (out_free) state_in = S_IDLE;
         end
         S_MD: if (md_cnt_ff == 5'(MD_STEPS - 1)) state_in = S_FIN;
         S_FIN: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_stall = (state_ff != S_IDLE);
   end

   // multiply / divide result from the serial unit
   always_comb begin
      logic        sa, sb, neg;
      logic [63:0] prod, prod_n;
      logic [31:0] q, r;
      sa     = (f3 == 3'd1) || (f3 == 3'd2);
      sb     = (f3 == 3'd1);
      neg    = (sa && a[31]) ^ (sb && b[31]);
      prod   = {md_hi_ff[31:0], md_lo_ff};
      prod_n = neg ? (~prod + 64'd1) : prod;
      q      = md_lo_ff;
      r      = md_hi_ff[31:0];
      unique case (f3)
         3'd0: md_result = prod[31:0];
         3'd1, 3'd2, 3'd3: md_result = prod_n[63:32];
         3'd4: md_result = (b == 32'd0) ? 32'hffff_ffff :
                           ((a[31] ^ b[31]) ? (32'd0 - q) : q);
         3'd5: md_result = (b == 32'd0) ? 32'hffff_ffff : q;
         3'd6: md_result = (b == 32'd0) ? a : (a[31] ? (32'd0 - r) : r);
         default: md_result = (b == 32'd0) ? a : r;
      endcase
   end

   // execute: result item and state updates of one request
   always_comb begin
      logic [31:0] opb, v, npc, cv, ext;
      logic [4:0]  ch;
      logic        take, good;
      rsp_kind_in  = K_RETIRED;
      rsp_addr_in  = '0;
      rsp_wdata_in = '0;
      rsp_size_in  = '0;
      rsp_npc_in   = pc_ff;
      rsp_code_in  = '0;
      wb_en     = 1'b0;
      wb_addr   = rd;
      wb_data   = '0;
      pc_we     = 1'b0;
      pc_in     = pc_ff;
      csr_we    = 1'b0;
      csr_ix    = '0;
      csr_wdata = '0;
      do_ecall  = 1'b0;
      ld_set    = 1'b0;
      ld_clr    = 1'b0;
      halt_set  = 1'b0;
      opb  = (opc == OPC_OP) ? b : immi;
      v    = '0;
      npc  = pc4;
      take = 1'b0;
      good = 1'b1;
      ch   = csr_lookup(ins_ff[31:20]);
      cv   = csr_file_ff[ch[3:0]];
      unique case (ld_width_ff)
         2'd0: ext = ld_signed_ff ? {{24{ldata_ff[7]}}, ldata_ff[7:0]}
                                  : {24'd0, ldata_ff[7:0]};
         2'd1: ext = ld_signed_ff ? {{16{ldata_ff[15]}}, ldata_ff[15:0]}
                                  : {16'd0, ldata_ff[15:0]};
         default: ext = ldata_ff;
      endcase

      priority if (halted_ff) begin
         rsp_kind_in = K_HALT;
         rsp_code_in = a;
      end else if (op_ff) begin
         if (ld_pend_ff) begin
            wb_en   = 1'b1;
            wb_addr = ld_dest_ff;
            wb_data = ext;
            ld_clr  = 1'b1;
         end
      end else if (ld_pend_ff) begin
         rsp_kind_in = K_INVALID;
      end else begin
         unique case (opc)
            OPC_OP, OPC_OP_IMM: begin
               if ((opc == OPC_OP) && (f7 == F7_MULDIV)) v = md_result;
               else begin
                  unique case (f3)
                     3'd0: v = ((opc == OPC_OP) && (f7 == F7_ALT)) ? (a - opb) : (a + opb);
                     3'd1: v = a << opb[4:0];
                     3'd2: v = {31'd0, $signed(a) < $signed(opb)};
                     3'd3: v = {31'd0, a < opb};
                     3'd4: v = a ^ opb;
                     3'd5: v = (f7 == F7_ALT) ? 32'($signed(a) >>> opb[4:0])
                                              : (a >> opb[4:0]);
                     3'd6: v = a | opb;
                     default: v = a & opb;
                  endcase
                  if (opc == OPC_OP) begin
                     good = (f7 == F7_BASE) ||
                            ((f7 == F7_ALT) && ((f3 == 3'd0) || (f3 == 3'd5)));
                  end else if (f3 == 3'd1) begin
                     good = (f7 == F7_BASE);
                  end else if (f3 == 3'd5) begin
                     good = (f7 == F7_BASE) || (f7 == F7_ALT);
                  end
               end
               wb_en   = good;
               wb_data = v;
            end
            OPC_LOAD: begin
               if ((f3 == 3'd3) || (f3 > 3'd5)) good = 1'b0;
               else begin
                  ld_set      = 1'b1;
                  rsp_kind_in = K_LOAD;
                  rsp_addr_in = a + immi;
                  rsp_size_in = 3'd1 << f3[1:0];
               end
            end
            OPC_STORE: begin
               if (f3 > 3'd2) good = 1'b0;
               else begin
                  rsp_kind_in  = K_STORE;
                  rsp_addr_in  = a + imms;
                  rsp_wdata_in = b;
                  rsp_size_in  = 3'd1 << f3[1:0];
               end
            end
            OPC_BRANCH: begin
               unique case (f3)
                  3'd0: take = (a == b);
                  3'd1: take = (a != b);
                  3'd4: take = ($signed(a) < $signed(b));
                  3'd5: take = !($signed(a) < $signed(b));
                  3'd6: take = (a < b);
                  3'd7: take = (a >= b);
                  default: good = 1'b0;
               endcase
               if (take) npc = pc_ff + immb;
            end
            OPC_LUI: begin
               wb_en   = 1'b1;
               wb_data = immu;
            end
            OPC_AUIPC: begin
               wb_en   = 1'b1;
               wb_data = pc_ff + immu;
            end
            OPC_JAL: begin
               wb_en   = 1'b1;
               wb_data = pc4;
               npc     = pc_ff + immj;
            end
            OPC_JALR: begin
               if (f3 != 3'd0) good = 1'b0;
               else begin
                  wb_en   = 1'b1;
                  wb_data = pc4;
                  npc     = (a + immi) & 32'hffff_fffe;
               end
            end
            OPC_SYSTEM: begin
               priority if (ins_ff == INSN_MRET) begin
                  csr_we    = 1'b1;
                  csr_ix    = CSR_MSTATUS_IX;
                  csr_wdata = {csr_file_ff[CSR_MSTATUS_IX][31:4],
                               csr_file_ff[CSR_MSTATUS_IX][7],
                               csr_file_ff[CSR_MSTATUS_IX][2:0]};
                  npc       = csr_file_ff[CSR_MEPC_IX];
               end else if (ins_ff == INSN_ECALL) begin
                  do_ecall = 1'b1;
                  npc      = csr_file_ff[CSR_MTVEC_IX];
               end else if (ins_ff == INSN_EBREAK) begin
                  halt_set    = 1'b1;
                  rsp_kind_in = K_HALT;
                  rsp_code_in = a;
               end else if ((f3 >= 3'd1) && (f3 <= 3'd3)) begin
                  if (!ch[4]) rsp_kind_in = K_BADCSR;
                  else begin
                     csr_we = 1'b1;
                     csr_ix = ch[3:0];
                     unique case (f3)
                        3'd1: csr_wdata = a;
                        3'd2: csr_wdata = cv | a;
                        default: csr_wdata = cv & ~a;
                     endcase
                     wb_en   = 1'b1;
                     wb_data = cv;
                  end
               end else begin
                  good = 1'b0;
               end
            end
            default: good = 1'b0;
         endcase

         if (!good) begin
            rsp_kind_in = K_INVALID;
            wb_en       = 1'b0;
         end else if (rsp_kind_in != K_HALT && rsp_kind_in != K_BADCSR) begin
            if (rsp_kind_in == K_RETIRED) pc_in = npc;
            else pc_in = pc4;
            pc_we      = 1'b1;
            rsp_npc_in = pc_in;
         end
      end
   end

   assign reg_we = commit && wb_en && (wb_addr != 5'd0) && (32'(wb_addr) < REG_COUNT);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= RESET_VECTOR;
         halted_ff    <= 1'b0;
         ld_pend_ff   <= 1'b0;
         ld_dest_ff   <= '0;
         ld_width_ff  <= '0;
         ld_signed_ff <= 1'b0;
         reg_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         md_cnt_ff    <= '0;
         for (int k = 0; k < CSR_COUNT; k++) csr_file_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            pc_ff <= csr_write_data;
         end else if (commit && pc_we) begin
            pc_ff <= pc_in;
         end
         if (commit) begin
            if (halt_set) halted_ff <= 1'b1;
            if (ld_set) begin
               ld_pend_ff   <= 1'b1;
               ld_dest_ff   <= rd;
               ld_width_ff  <= f3[1:0];
               ld_signed_ff <= !f3[2];
            end else if (ld_clr) begin
               ld_pend_ff <= 1'b0;
            end
            if (csr_we) csr_file_ff[csr_ix] <= csr_wdata;
            if (do_ecall) begin
               csr_file_ff[CSR_MEPC_IX]   <= pc_ff;
               csr_file_ff[CSR_MCAUSE_IX] <= a;
            end
         end
         if (reg_we) reg_vld_ff[wb_addr[REG_AW-1:0]] <= 1'b1;
         if (state_ff == S_MD) md_cnt_ff <= md_cnt_ff + 5'd1;
         else md_cnt_ff <= '0;
         if (commit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // register file memory, read data registered at accept
   always_ff @(posedge clock) begin
      if (reg_we) reg_mem[wb_addr[REG_AW-1:0]] <= wb_data;
      if (accept) begin
         a_raw_ff <= reg_mem[ra[REG_AW-1:0]];
         b_raw_ff <= reg_mem[rb[REG_AW-1:0]];
         a_ok_ff  <= (ra != 5'd0) && (32'(ra) < REG_COUNT) && reg_vld_ff[ra[REG_AW-1:0]];
         b_ok_ff  <= (rb != 5'd0) && (32'(rb) < REG_COUNT) && reg_vld_ff[rb[REG_AW-1:0]];
      end
   end

   // request latch, serial unit and result payload
   always_ff @(posedge clock) begin
      logic [32:0] sum;
      logic [32:0] rem_sh;
      logic [33:0] diff;
      if (accept) begin
         op_ff    <= req_op;
         ins_ff   <= req_instruction;
         ldata_ff <= req_load_data;
      end
      if ((state_ff == S_EXEC) && is_md) begin
         // magnitudes of signed operands: shift-add works on |a|*|b|, divide on |a|/|b|
         md_hi_ff <= '0;
         if (is_div) begin
            md_lo_ff   <= (!f3[0] && a[31]) ? (32'd0 - a) : a;
            md_opnd_ff <= (!f3[0] && b[31]) ? (32'd0 - b) : b;
         end else begin
            md_lo_ff   <= ((f3 == 3'd1) && b[31]) ? (32'd0 - b) : b;
            md_opnd_ff <= (((f3 == 3'd1) || (f3 == 3'd2)) && a[31]) ? (32'd0 - a) : a;
         end
      end else if (state_ff == S_MD) begin
         if (is_div) begin
            rem_sh = {md_hi_ff[31:0], md_lo_ff[31]};
            diff   = {1'b0, rem_sh} - {2'b00, md_opnd_ff};
            if (!diff[33]) begin
               md_hi_ff <= diff[32:0];
               md_lo_ff <= {md_lo_ff[30:0], 1'b1};
            end else begin
               md_hi_ff <= rem_sh;
               md_lo_ff <= {md_lo_ff[30:0], 1'b0};
            end
         end else begin
            sum = md_hi_ff + (md_lo_ff[0] ? {1'b0, md_opnd_ff} : 33'd0);
            md_hi_ff <= {1'b0, sum[32:1]};
            md_lo_ff <= {sum[0], md_lo_ff[31:1]};
         end
      end
      if (commit) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_addr_ff  <= rsp_addr_in;
         rsp_wdata_ff <= rsp_wdata_in;
         rsp_size_ff  <= rsp_size_in;
         rsp_npc_ff   <= rsp_npc_in;
         rsp_code_ff  <= rsp_code_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_mem_address    = rsp_addr_ff;
   assign rsp_mem_write_data = rsp_wdata_ff;
   assign rsp_mem_size       = rsp_size_ff;
   assign rsp_next_pc        = rsp_npc_ff;
   assign rsp_exit_code      = rsp_code_ff;

   // once halted, only reset leaves the halt
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag dropped");

   // x0 is never written
   a_x0_write: assert property (@(posedge clock) disable iff (reset)
      reg_we |-> (wb_addr != 5'd0))
      else $error("write to x0");

   // a taken request goes straight to execute
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted request not in execute");

   // the serial unit finishes only after running its steps
   a_fin_after_md: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> ($past(state_ff) == S_MD || $past(state_ff) == S_FIN))
      else $error("serial result without iteration");

endmodule
